FILE: design/sit_pkg.sv
// shared widths and the data word handed along the square root chain
package sit_pkg;

    localparam int unsigned CoordW   = 32;
    localparam int unsigned OffW     = CoordW + 1;
    localparam int unsigned AbsW     = CoordW;
    localparam int unsigned SqW      = 2 * AbsW;
    localparam int unsigned RadW     = SqW + 2;
    localparam int unsigned RootW    = RadW / 2;
    localparam int unsigned RemW     = RootW + 4;
    localparam int unsigned NormW    = 16;
    localparam int unsigned ProdW    = NormW + OffW;
    localparam int unsigned DotW     = ProdW + 2;
    localparam int unsigned AdotW    = DotW - 1;
    localparam int unsigned IndexW   = 32;
    localparam int unsigned RadiusW  = 31;
    localparam int unsigned CosW     = 15;
    localparam int unsigned BoundW   = CosW + RootW;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;

    typedef struct packed {
        logic                valid;
        logic [RadW-1:0]     rad;
        logic [RemW-1:0]     rem;
        logic [RootW-1:0]    root;
        logic [AdotW-1:0]    adot;
        logic [IndexW-1:0]   index;
    } t_chain;

endpackage

FILE: design/sit_sqrt_cell.sv
// one digit step of the integer square root, one root bit per cell
module sit_sqrt_cell
    import sit_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_chain i_data,
    output t_chain o_data
);

    t_chain           r_data;
    t_chain           n_data;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    always_comb begin
        rem_sh = {i_data.rem[RemW-3:0], i_data.rad[RadW-1 -: 2]};
        trial  = {2'b00, i_data.root, 2'b01};
        ge     = (rem_sh >= trial);
        n_data       = i_data;
        n_data.rad   = {i_data.rad[RadW-3:0], 2'b00};
        n_data.rem   = ge ? (rem_sh - trial) : rem_sh;
        n_data.root  = {i_data.root[RootW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end
    end

    assign o_data = r_data;

endmodule

FILE: design/sphere_inlier_test.sv
// sphere inlier test: offset, squares, square root chain and final tests
//
//  channel   direction  handshake                 payload
//  point     in         start, busy               i_point_*, i_normal_*, i_point_index
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//  inlier    out        o_inlier_valid strobe     o_inlier_index
//
// one point per cycle through the stage registers and the chain of 33 root cells
// busy stays low: the pipeline never stalls and the receiver takes every strobe
// reset (i_rst_n low, synchronous) clears every valid bit and the config registers to zero
module sphere_inlier_test
    import sit_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [CoordW-1:0]  i_point_x,
    input  logic signed [CoordW-1:0]  i_point_y,
    input  logic signed [CoordW-1:0]  i_point_z,
    input  logic signed [NormW-1:0]   i_normal_x,
    input  logic signed [NormW-1:0]   i_normal_y,
    input  logic signed [NormW-1:0]   i_normal_z,
    input  logic [IndexW-1:0]         i_point_index,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [CfgDataW-1:0]       i_cfg_data,
    output logic                      o_inlier_valid,
    output logic [IndexW-1:0]         o_inlier_index
);

    typedef enum logic [CfgIdxW-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_DIST_TOL = 3'd4,
        REG_COS_TOL  = 3'd5
    } t_reg_idx;

    logic signed [CoordW-1:0] r_cx, r_cy, r_cz;
    logic [RadiusW-1:0]       r_radius, r_dtol;
    logic [CosW-1:0]          r_cos;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= '0;
            r_dtol   <= '0;
            r_cos    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CENTER_X: r_cx     <= i_cfg_data;
                REG_CENTER_Y: r_cy     <= i_cfg_data;
                REG_CENTER_Z: r_cz     <= i_cfg_data;
                REG_RADIUS:   r_radius <= i_cfg_data[RadiusW-1:0];
                REG_DIST_TOL: r_dtol   <= i_cfg_data[RadiusW-1:0];
                REG_COS_TOL:  r_cos    <= i_cfg_data[CosW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: offsets
    logic                     r_v1;
    logic signed [OffW-1:0]   r_dx, r_dy, r_dz;
    logic signed [NormW-1:0]  r_nx, r_ny, r_nz;
    logic [IndexW-1:0]        r_idx1;

    always_ff @(posedge i_clk) begin
        r_v1   <= start & ~busy;
        r_dx   <= OffW'(i_point_x) - OffW'(r_cx);
        r_dy   <= OffW'(i_point_y) - OffW'(r_cy);
        r_dz   <= OffW'(i_point_z) - OffW'(r_cz);
        r_nx   <= i_normal_x;
        r_ny   <= i_normal_y;
        r_nz   <= i_normal_z;
        r_idx1 <= i_point_index;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end
    end

    // stage 2: squares and normal products
    logic [AbsW-1:0]          ax, ay, az;
    logic signed [OffW-1:0]   nabs_x, nabs_y, nabs_z;
    logic                     r_v2;
    logic [SqW-1:0]           r_sx, r_sy, r_sz;
    logic signed [ProdW-1:0]  r_px, r_py, r_pz;
    logic [IndexW-1:0]        r_idx2;

    always_comb begin
        nabs_x = r_dx[OffW-1] ? -r_dx : r_dx;
        nabs_y = r_dy[OffW-1] ? -r_dy : r_dy;
        nabs_z = r_dz[OffW-1] ? -r_dz : r_dz;
        ax = nabs_x[AbsW-1:0];
        ay = nabs_y[AbsW-1:0];
        az = nabs_z[AbsW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_v2   <= r_v1;
        r_sx   <= SqW'(ax) * SqW'(ax);
        r_sy   <= SqW'(ay) * SqW'(ay);
        r_sz   <= SqW'(az) * SqW'(az);
        r_px   <= ProdW'(r_nx) * ProdW'(r_dx);
        r_py   <= ProdW'(r_ny) * ProdW'(r_dy);
        r_pz   <= ProdW'(r_nz) * ProdW'(r_dz);
        r_idx2 <= r_idx1;
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end
    end

    // stage 3: sums, feeds the root chain
    t_chain                  chain [RootW+1];
    t_chain                  r_head;
    logic signed [DotW-1:0]  dot;
    logic signed [DotW-1:0]  dot_abs;

    always_comb begin
        dot     = DotW'(r_px) + DotW'(r_py) + DotW'(r_pz);
        dot_abs = dot[DotW-1] ? -dot : dot;
    end

    always_ff @(posedge i_clk) begin
        r_head.valid <= r_v2;
        r_head.rad   <= RadW'(r_sx) + RadW'(r_sy) + RadW'(r_sz);
        r_head.rem   <= '0;
        r_head.root  <= '0;
        r_head.adot  <= dot_abs[AdotW-1:0];
        r_head.index <= r_idx2;
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end
    end

    assign chain[0] = r_head;

    for (genvar g = 0; g < RootW; g++) begin : g_cell
        sit_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_data (chain[g]),
            .o_data (chain[g+1])
        );
    end

    // stage after chain: radial error and cosine bound
    t_chain                   tail;
    logic signed [RootW:0]    err;
    logic                     r_v4;
    logic                     r_nz_len;
    logic                     r_dist_ok;
    logic [BoundW-1:0]        r_bound;
    logic [AdotW-1:0]         r_adot;
    logic [IndexW-1:0]        r_idx4;

    always_comb begin
        tail = chain[RootW];
        err  = (RootW+1)'(tail.root) - (RootW+1)'(r_radius);
        if (err[RootW]) begin
            err = -err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v4      <= tail.valid;
        r_nz_len  <= (tail.root != '0);
        r_dist_ok <= (err < (RootW+1)'(r_dtol));
        r_bound   <= BoundW'(r_cos) * BoundW'(tail.root);
        r_adot    <= tail.adot;
        r_idx4    <= tail.index;
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end
    end

    logic              r_out_v;
    logic [IndexW-1:0] r_out_idx;

    always_ff @(posedge i_clk) begin
        r_out_v   <= r_v4 & r_nz_len & r_dist_ok & (r_adot > AdotW'(r_bound));
        r_out_idx <= r_idx4;
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_inlier_valid = r_out_v;
    assign o_inlier_index = r_out_idx;

endmodule
